// ----- hdl/u8u16_pkg.sv -----
package u8u16_pkg;

  localparam int unsigned MaxUnits = 4;

  localparam logic [15:0] ReplChar   = 16'hFFFD;
  localparam logic [15:0] HiSurrBase = 16'hD800;
  localparam logic [15:0] LoSurrBase = 16'hDC00;
  localparam logic [20:0] SuppBase   = 21'h10000;

  // decoder state carried between bytes
  typedef struct packed {
    logic [20:0] pend;
    logic [1:0]  need;
    logic [1:0]  seen;
  } st_t;

  // everything one byte produces
  typedef struct packed {
    logic [MaxUnits-1:0][15:0] units;
    logic [2:0]                n;
    st_t                       st;
  } dec_t;

endpackage

// ----- hdl/utf8_to_utf16_transcoder.sv -----
// UTF-8 to UTF-16 stream transcoder.
// Input channel: one UTF-8 byte per transaction on in_byte, with in_last
// marking the final byte of a string. Output channel: one UTF-16 code unit
// per transaction on out_code_unit, with out_unit_last on the final unit of
// the string. Surrogate pairs come out high half first.
// Each accepted byte is decoded in the same cycle and its zero to four code
// units are loaded into a result buffer; the first unit is visible in the cycle
// after acceptance. The buffer drains one unit per cycle while out_stall is low.
// Throughput: one byte per cycle while every byte yields at most one unit and
// out_stall is low; a byte that yields several units holds the input until the
// single output port has drained the result buffer. in_stall is low when the
// buffer is empty or its last unit is taken in the same cycle.
// A stall on the output holds the current unit and, while the buffer is not
// empty, stalls the input as well.
// Reset (rst_n low, synchronous) empties the buffer and closes any open
// sequence.
module utf8_to_utf16_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_unit_last
);
  import u8u16_pkg::*;

  st_t                       st_r;
  logic [2:0]                rem_r;
  logic                      last_r;
  logic [MaxUnits-1:0][15:0] u_r;
  dec_t                      dec;
  logic                      acc;
  logic                      take;

  u8u16_decode u_dec (
    .in_byte (in_byte),
    .in_last (in_last),
    .st      (st_r),
    .dec     (dec)
  );

  assign out_valid     = (rem_r != 3'd0);
  assign take          = out_valid && !out_stall;
  assign in_stall      = (rem_r > 3'd1) || ((rem_r == 3'd1) && out_stall);
  assign acc           = in_valid && !in_stall;
  assign out_code_unit = u_r[0];
  assign out_unit_last = last_r && (rem_r == 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      rem_r <= 3'd0;
    end else if (acc) begin
      st_r  <= dec.st;
      rem_r <= dec.n;
    end else if (take) begin
      rem_r <= rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      u_r    <= dec.units;
      last_r <= in_last;
    end else if (take) begin
      for (int i = 0; i < MaxUnits - 1; i++) u_r[i] <= u_r[i+1];
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'(MaxUnits))
    else $error("result buffer count out of range");

  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last |=> st_r.need == 2'd0)
    else $error("sequence left open after end of string");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.need == 2'd0 |-> st_r.pend == 21'd0 && st_r.seen == 2'd0)
    else $error("stale sequence state with no sequence open");

  a_seen_lt_need: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.need != 2'd0 |-> st_r.seen < st_r.need)
    else $error("continuation count reached need without completing");

  a_last_has_unit: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last |=> rem_r != 3'd0)
    else $error("end of string produced no code unit");

endmodule

// ----- hdl/u8u16_decode.sv -----
module u8u16_decode (
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  u8u16_pkg::st_t  st,
  output u8u16_pkg::dec_t dec
);
  import u8u16_pkg::*;

  logic        is_cont;
  logic        f_ascii;
  logic        f_lead2;
  logic        f_lead3;
  logic        f_lead4;
  logic        f_lead;
  logic [1:0]  f_need;
  logic [20:0] f_pend;
  logic        f_n;
  logic [15:0] f_unit;
  st_t         f_st;
  logic [20:0] pend_new;
  logic [1:0]  seen_inc;
  logic [20:0] v;
  logic [2:0]  ab;

  always_comb begin
    is_cont = (in_byte[7:6] == 2'b10);
    f_ascii = !in_byte[7];
    f_lead2 = (in_byte[7:5] == 3'b110);
    f_lead3 = (in_byte[7:4] == 4'b1110);
    f_lead4 = (in_byte[7:3] == 5'b11110);
    f_lead  = f_lead2 || f_lead3 || f_lead4;
    if (f_lead2) begin
      f_need = 2'd1;
      f_pend = {16'd0, in_byte[4:0]};
    end else if (f_lead3) begin
      f_need = 2'd2;
      f_pend = {17'd0, in_byte[3:0]};
    end else begin
      f_need = 2'd3;
      f_pend = {18'd0, in_byte[2:0]};
    end
    // a lead on the last byte is cut short at once
    f_n    = !f_lead || in_last;
    f_unit = f_ascii ? {8'd0, in_byte} : ReplChar;
    if (f_lead && !in_last) begin
      f_st.pend = f_pend;
      f_st.need = f_need;
      f_st.seen = 2'd0;
    end else begin
      f_st = '0;
    end

    pend_new = {st.pend[14:0], in_byte[5:0]};
    seen_inc = st.seen + 2'd1;
    v        = pend_new - SuppBase;
    ab       = {1'b0, st.seen} + 3'd1;

    for (int i = 0; i < MaxUnits; i++) dec.units[i] = ReplChar;
    dec.n  = 3'd0;
    dec.st = '0;

    if (st.need != 2'd0 && is_cont) begin
      if (seen_inc >= st.need) begin
        if (pend_new[20:16] == 5'd0) begin
          dec.n        = 3'd1;
          dec.units[0] = pend_new[15:0];
        end else begin
          dec.n        = 3'd2;
          dec.units[0] = HiSurrBase + {5'd0, v[20:10]};
          dec.units[1] = LoSurrBase | {6'd0, v[9:0]};
        end
      end else if (in_last) begin
        dec.n = {1'b0, seen_inc} + 3'd1;
      end else begin
        dec.st.pend = pend_new;
        dec.st.need = st.need;
        dec.st.seen = seen_inc;
      end
    end else if (st.need != 2'd0) begin
      // broken sequence: lead and collected bytes, then restart on this byte
      dec.n  = ab + {2'd0, f_n};
      dec.st = f_st;
      if (f_n) dec.units[ab[1:0]] = f_unit;
    end else begin
      dec.n        = {2'd0, f_n};
      dec.units[0] = f_unit;
      dec.st       = f_st;
    end
  end

endmodule
